### rtl/acc_alu_pkg.sv
// operation codes and field widths for the 8-bit accumulator alu
package acc_alu_pkg;

	localparam int unsigned DATA_W = 8;
	localparam int unsigned ADDR_W = 14;
	localparam int unsigned OP_W   = 4;

	// stream widths, padded to whole bytes
	localparam int unsigned IN_W   = 32;
	localparam int unsigned OUT_W  = 40;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 4'd0,
		OP_ADC   = 4'd1,
		OP_AND   = 4'd2,
		OP_OR    = 4'd3,
		OP_XOR   = 4'd4,
		OP_CMP   = 4'd5,
		OP_LOAD  = 4'd6,
		OP_STORE = 4'd7,
		OP_MOVE  = 4'd8,
		OP_INC   = 4'd9,
		OP_DEC   = 4'd10,
		OP_CLR   = 4'd11,
		OP_LSR   = 4'd12,
		OP_LSL   = 4'd13,
		OP_ROL   = 4'd14,
		OP_ROR   = 4'd15
	} alu_op_t;

	typedef struct packed {
		logic [DATA_W-1:0] write_data;
		logic [ADDR_W-1:0] write_address;
		logic              write_enable;
		logic              zero_out;
		logic              carry_out;
		logic [DATA_W-1:0] accumulator_out;
	} alu_result_t;

endpackage

### rtl/accumulator_alu_8bit_cz.sv
// 8-bit accumulator alu with carry and zero flags, stream in and out
// an input transfer is captured in the input stage register, then passes through the alu
// logic into the result register once that register is free or being drained
// throughput: one instruction per cycle without output stall; input register feeds one
// alu pass into the result register; accumulator and flags update on that same edge
// a stalled output holds its result while one more instruction waits in the input stage
// reset: arst_n asynchronously clears the accumulator, carry, zero and both valid bits
module accumulator_alu_8bit_cz
	import acc_alu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// [3:0] operation, [11:4] operand, [25:12] address, [31:26] zero
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [7:0] accumulator_out, [8] carry_out, [9] zero_out, [10] write_enable,
	// [24:11] write_address, [32:25] write_data, [39:33] zero
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int unsigned RES_W = $bits(alu_result_t);

	// input stage
	logic              valid_s1;
	alu_op_t           op_s1;
	logic [DATA_W-1:0] operand_s1;
	logic [ADDR_W-1:0] address_s1;

	// architectural state
	logic [DATA_W-1:0] acc_q;
	logic              carry_q;
	logic              zero_q;

	// result register
	logic              out_valid_q;
	alu_result_t       result_q;

	logic              advance;
	alu_result_t       result_d;

	// the input stage moves on whenever the result register is free or being drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload of the input stage needs no reset
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1      <= alu_op_t'(s_axis_tdata[OP_W-1:0]);
			operand_s1 <= s_axis_tdata[OP_W +: DATA_W];
			address_s1 <= s_axis_tdata[OP_W+DATA_W +: ADDR_W];
		end
	end

	// single pass of alu logic from the input stage and current state
	always_comb begin
		logic [DATA_W:0]   sum;
		logic [DATA_W-1:0] diff;
		logic [DATA_W-1:0] acc_n;
		logic              carry_n;
		logic              we_n;
		logic [DATA_W-1:0] wd_n;
		logic              zero_n;

		sum     = {1'b0, acc_q} + {1'b0, operand_s1}
			+ {{DATA_W{1'b0}}, (op_s1 == OP_ADC) && carry_q};
		diff    = acc_q - operand_s1;
		acc_n   = acc_q;
		carry_n = carry_q;
		we_n    = 1'b0;
		wd_n    = '0;
		zero_n  = zero_q;

		unique case (op_s1)
			OP_ADD, OP_ADC: begin
				acc_n   = sum[DATA_W-1:0];
				carry_n = sum[DATA_W];
				zero_n  = (sum[DATA_W-1:0] == '0);
			end
			OP_AND: begin
				acc_n  = acc_q & operand_s1;
				zero_n = (acc_n == '0);
			end
			OP_OR: begin
				acc_n  = acc_q | operand_s1;
				zero_n = (acc_n == '0);
			end
			OP_XOR: begin
				acc_n  = acc_q ^ operand_s1;
				zero_n = (acc_n == '0);
			end
			OP_CMP: begin
				// borrow out of the subtract, accumulator kept
				zero_n  = (acc_q == operand_s1);
				carry_n = (!acc_q[DATA_W-1] && operand_s1[DATA_W-1])
					|| (operand_s1[DATA_W-1] && diff[DATA_W-1])
					|| (diff[DATA_W-1] && !acc_q[DATA_W-1]);
			end
			OP_LOAD: begin
				acc_n  = operand_s1;
				zero_n = (operand_s1 == '0);
			end
			OP_STORE: begin
				we_n   = 1'b1;
				wd_n   = acc_q;
				zero_n = (acc_q == '0);
			end
			OP_MOVE: begin
				we_n   = 1'b1;
				wd_n   = operand_s1;
				zero_n = (operand_s1 == '0);
			end
			OP_INC: begin
				we_n   = 1'b1;
				wd_n   = operand_s1 + DATA_W'(1);
				zero_n = (wd_n == '0);
			end
			OP_DEC: begin
				we_n   = 1'b1;
				wd_n   = operand_s1 - DATA_W'(1);
				zero_n = (wd_n == '0);
			end
			OP_CLR: begin
				we_n    = 1'b1;
				acc_n   = '0;
				carry_n = 1'b0;
				zero_n  = 1'b1;
			end
			OP_LSR: begin
				carry_n = acc_q[0];
				acc_n   = {1'b0, acc_q[DATA_W-1:1]};
				zero_n  = (acc_n == '0);
			end
			OP_LSL: begin
				carry_n = acc_q[DATA_W-1];
				acc_n   = {acc_q[DATA_W-2:0], 1'b0};
				zero_n  = (acc_n == '0);
			end
			OP_ROL: begin
				// old carry comes in at the bottom
				carry_n = acc_q[DATA_W-1];
				acc_n   = {acc_q[DATA_W-2:0], carry_q};
				zero_n  = (acc_n == '0);
			end
			OP_ROR: begin
				// old carry comes in at the top
				carry_n = acc_q[0];
				acc_n   = {carry_q, acc_q[DATA_W-1:1]};
				zero_n  = (acc_n == '0);
			end
			default: begin
				acc_n = acc_q;
			end
		endcase

		result_d.accumulator_out = acc_n;
		result_d.carry_out       = carry_n;
		result_d.zero_out        = zero_n;
		result_d.write_enable    = we_n;
		result_d.write_address   = address_s1;
		result_d.write_data      = wd_n;
	end

	// state and result valid update together when an instruction leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			carry_q     <= 1'b0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				acc_q   <= result_d.accumulator_out;
				carry_q <= result_d.carry_out;
				zero_q  <= result_d.zero_out;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W-RES_W){1'b0}}, result_q};

	// the state register always matches the most recently produced result
	a_state_tracks_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (acc_q == result_q.accumulator_out) && (carry_q == result_q.carry_out)
			&& (zero_q == result_q.zero_out))
		else $error("accumulator state diverged from the result register");

	// an instruction in the input stage is never dropped while the output stalls
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage instruction lost");

	// input back-pressure only when both stages are full and the output stalls
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled without a full pipeline");

	// no memory write means a zero data byte
	a_no_write_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !result_q.write_enable |-> result_q.write_data == '0)
		else $error("write data set without write enable");

endmodule
